// ----- rtl/core/address_decoder_exclusive_monitor_macros.svh -----
// Assertion macros for the address decoder with exclusive monitor.
// Used by the top level in rtl/core; needs clk and rst_n in scope.
`ifndef ADDRESS_DECODER_EXCLUSIVE_MONITOR_MACROS_SVH
`define ADDRESS_DECODER_EXCLUSIVE_MONITOR_MACROS_SVH

// Checked only outside reset.
`define ADEM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ADEM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/adem_pkg.sv -----
// Package for the address decoder with exclusive monitor.
// Types, sizes, command codes and register indexes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package adem_pkg;

    localparam int SEGMENTS    = 3;
    localparam int NUM_MASTERS = 8;
    localparam int SEG_IDX_W   = $clog2(SEGMENTS);
    localparam int ADDR_W      = 32;
    localparam int DATA_W      = 32;
    localparam int PORT_W      = 2;
    localparam int SIZE_W      = 2;
    localparam int ID_W        = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [DATA_W-1:0]          data_t;
    typedef logic [PORT_W-1:0]          port_t;
    typedef logic [SIZE_W-1:0]          size_t;
    typedef logic [ID_W-1:0]            master_id_t;
    typedef logic [NUM_MASTERS-1:0]     mask_t;
    typedef logic [SEG_IDX_W-1:0]       seg_idx_t;
    typedef logic [SEGMENTS-1:0]        seg_vec_t;
    typedef logic [PORT_W*SEGMENTS-1:0] seg_ports_t;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LL    = 2'd2,
        CMD_SC    = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_SEG0_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG0_END   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG1_BASE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG1_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG2_BASE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG2_END   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_PORTS  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SEG_ENABLE = 3'd7;

    // One-hot bit of a master; zero for an id at or above NUM_MASTERS.
    function automatic mask_t master_bit(input master_id_t id);
        mask_t m;
        m = '0;
        for (int i = 0; i < NUM_MASTERS; i++)
        begin
            if (int'(id) == i)
            begin
                m[i] = 1'b1;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/adem_if.sv -----
// Request and response channel interfaces for the address decoder.
// Depends on adem_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface adem_req_if;
    import adem_pkg::*;

    logic       valid;
    logic       ready;
    cmd_t       cmd;
    addr_t      address;
    data_t      write_data;
    size_t      access_size;
    master_id_t master_id;

    modport source (output valid, cmd, address, write_data, access_size, master_id,
                    input ready);
    modport sink   (input valid, cmd, address, write_data, access_size, master_id,
                    output ready);
endinterface

interface adem_rsp_if;
    import adem_pkg::*;

    logic  valid;
    logic  ready;
    port_t target_port;
    logic  decode_error;
    logic  forward_valid;
    logic  forward_is_write;
    addr_t out_address;
    data_t out_data;
    size_t out_size;
    logic  sc_success;

    modport source (output valid, target_port, decode_error, forward_valid,
                    forward_is_write, out_address, out_data, out_size, sc_success,
                    input ready);
    modport sink   (input valid, target_port, decode_error, forward_valid,
                    forward_is_write, out_address, out_data, out_size, sc_success,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/core/address_decoder_exclusive_monitor.sv -----
// Address decoder with per-segment exclusive monitor, top level.
// Depends on adem_pkg, adem_if and the assertion macro header.
//
// One request item in, one response item out, in order. An item is taken
// into an input register, decoded against the three segments and the
// reservation masks are updated as it moves into the response register, and
// one item is accepted every cycle while the response side keeps up. The
// reservation masks are read and written in that single decode stage, so
// back-to-back accesses to the same segment see each other's updates. The user
// must write segment registers through cfg_we/cfg_index/cfg_data only while
// no item is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

`include "address_decoder_exclusive_monitor_macros.svh"

module address_decoder_exclusive_monitor (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [adem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [adem_pkg::CFG_DATA_W-1:0] cfg_data,
    adem_req_if.sink                            req,
    adem_rsp_if.source                          rsp
);
    import adem_pkg::*;

    // configuration
    addr_t      seg_base_reg [SEGMENTS];
    addr_t      seg_end_reg  [SEGMENTS];
    seg_ports_t seg_ports_reg;
    seg_vec_t   seg_enable_reg;

    // input stage
    logic       s1_valid_reg;
    cmd_t       s1_cmd_reg;
    addr_t      s1_addr_reg;
    data_t      s1_data_reg;
    size_t      s1_size_reg;
    master_id_t s1_id_reg;

    // reservation state
    mask_t      masks_reg  [SEGMENTS];
    mask_t      masks_next [SEGMENTS];

    // response stage
    logic       out_valid_reg;
    port_t      out_port_reg,    out_port_next;
    logic       out_derr_reg,    out_derr_next;
    logic       out_fwd_reg,     out_fwd_next;
    logic       out_wr_reg,      out_wr_next;
    addr_t      out_addr_reg,    out_addr_next;
    data_t      out_data_reg,    out_data_next;
    size_t      out_size_reg,    out_size_next;
    logic       out_sc_reg,      out_sc_next;

    logic       s1_adv;
    logic       s1_fire;
    seg_vec_t   hit_raw;
    logic       hit_any;
    seg_idx_t   hit_idx;
    port_t      hit_port;
    mask_t      cur_mask;
    mask_t      id_bit;
    logic       sc_fire;

    assign s1_adv    = !out_valid_reg || rsp.ready;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign req.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEGMENTS; i++)
            begin
                seg_base_reg[i] <= '0;
                seg_end_reg[i]  <= '0;
            end
            seg_ports_reg  <= '0;
            seg_enable_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEG0_BASE:  seg_base_reg[0] <= cfg_data;
                CFG_SEG0_END:   seg_end_reg[0]  <= cfg_data;
                CFG_SEG1_BASE:  seg_base_reg[1] <= cfg_data;
                CFG_SEG1_END:   seg_end_reg[1]  <= cfg_data;
                CFG_SEG2_BASE:  seg_base_reg[2] <= cfg_data;
                CFG_SEG2_END:   seg_end_reg[2]  <= cfg_data;
                CFG_SEG_PORTS:  seg_ports_reg   <= cfg_data[PORT_W*SEGMENTS-1:0];
                CFG_SEG_ENABLE: seg_enable_reg  <= cfg_data[SEGMENTS-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_cmd_reg  <= req.cmd;
            s1_addr_reg <= req.address;
            s1_data_reg <= req.write_data;
            s1_size_reg <= req.access_size;
            s1_id_reg   <= req.master_id;
        end
    end

    // lowest-numbered enabled segment wins
    always_comb
    begin
        hit_idx  = '0;
        hit_port = '0;
        for (int i = 0; i < SEGMENTS; i++)
        begin
            hit_raw[i] = seg_enable_reg[i] && (s1_addr_reg >= seg_base_reg[i])
                         && (s1_addr_reg <= seg_end_reg[i]);
        end
        for (int i = SEGMENTS - 1; i >= 0; i--)
        begin
            if (hit_raw[i])
            begin
                hit_idx  = SEG_IDX_W'(i);
                hit_port = seg_ports_reg[PORT_W*i +: PORT_W];
            end
        end
        hit_any = |hit_raw;
    end

    assign cur_mask = masks_reg[hit_idx];
    assign id_bit   = master_bit(s1_id_reg);
    assign sc_fire  = s1_fire && hit_any && (s1_cmd_reg == CMD_SC);

    always_comb
    begin
        for (int i = 0; i < SEGMENTS; i++)
        begin
            masks_next[i] = masks_reg[i];
        end
        out_port_next = hit_any ? hit_port : '0;
        out_derr_next = !hit_any;
        out_fwd_next  = 1'b0;
        out_wr_next   = 1'b0;
        out_sc_next   = 1'b0;
        if (hit_any)
        begin
            case (s1_cmd_reg)
                CMD_READ:
                begin
                    out_fwd_next = 1'b1;
                end
                CMD_WRITE:
                begin
                    out_fwd_next = 1'b1;
                    out_wr_next  = 1'b1;
                end
                CMD_LL:
                begin
                    out_fwd_next = 1'b1;
                    if (s1_fire)
                    begin
                        masks_next[hit_idx] = cur_mask | id_bit;
                    end
                end
                CMD_SC:
                begin
                    out_sc_next  = |(cur_mask & id_bit);
                    out_fwd_next = out_sc_next;
                    out_wr_next  = out_sc_next;
                    if (s1_fire)
                    begin
                        masks_next[hit_idx] = '0;
                    end
                end
                default:
                begin
                    out_fwd_next = 1'b0;
                end
            endcase
        end
        out_addr_next = out_fwd_next ? s1_addr_reg : '0;
        out_data_next = out_wr_next  ? s1_data_reg : '0;
        out_size_next = out_fwd_next ? s1_size_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SEGMENTS; i++)
            begin
                masks_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < SEGMENTS; i++)
            begin
                masks_reg[i] <= masks_next[i];
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_port_reg <= out_port_next;
            out_derr_reg <= out_derr_next;
            out_fwd_reg  <= out_fwd_next;
            out_wr_reg   <= out_wr_next;
            out_addr_reg <= out_addr_next;
            out_data_reg <= out_data_next;
            out_size_reg <= out_size_next;
            out_sc_reg   <= out_sc_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.target_port      = out_port_reg;
    assign rsp.decode_error     = out_derr_reg;
    assign rsp.forward_valid    = out_fwd_reg;
    assign rsp.forward_is_write = out_wr_reg;
    assign rsp.out_address      = out_addr_reg;
    assign rsp.out_data         = out_data_reg;
    assign rsp.out_size         = out_size_reg;
    assign rsp.sc_success       = out_sc_reg;

    `ADEM_ASSERT(a_derr_no_fwd, rsp.valid && rsp.decode_error |-> rsp.target_port == '0 && !rsp.forward_valid && !rsp.sc_success, "decode error forwarded")
    `ADEM_ASSERT(a_sc_is_write, rsp.valid && rsp.sc_success |-> rsp.forward_valid && rsp.forward_is_write, "sc success not forwarded as write")
    `ADEM_ASSERT(a_sc_clears, sc_fire |=> masks_reg[$past(hit_idx)] == '0, "sc left reservations")
    `ADEM_ASSERT_ALWAYS(a_no_fire_empty, !rst_n || !out_valid_reg || s1_adv || !req.ready || !s1_valid_reg, "input stage overrun")

endmodule

`default_nettype wire
